[hdl/rcfcd_pkg.sv]
// Package for the RC frame channel decoder: buffer geometry, frame constants
// and the scaling constants used by the decoder's pulse scaling unit.
// No dependencies.
package rcfcd_pkg;

    localparam int BUF_BYTES = 64;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int CH_COUNT  = 16;
    localparam int MAX_LEN   = BUF_BYTES - 2;
    localparam int LEN_W     = 6;
    localparam int RAW_BITS  = 11;
    localparam int ACC_W     = RAW_BITS + 7;
    localparam int NBITS_W   = 5;
    localparam int FIRST_CH_BYTE = 3;
    localparam int TYPE_BYTE     = 2;

    localparam logic [7:0] SYNC_RESET = 8'd200;
    localparam logic [7:0] TYPE_RC    = 8'h16;

    localparam int RAW_MIN  = 172;
    localparam int RAW_MAX  = 1811;
    localparam int US_BASE  = 1000;
    localparam int DIVISOR  = RAW_MAX - RAW_MIN;
    localparam int RCP_SHIFT = 32;
    localparam logic [21:0] RECIP = 22'((64'd1 << RCP_SHIFT) / DIVISOR);

    localparam int MUL_W  = 22;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MAG_W  = 21;

endpackage

[hdl/rc_frame_channel_decoder.sv]
// RC frame channel decoder top level: sync/length framing, byte buffer and
// the channel unpack sequencer. Depends on rcfcd_pkg, rcfcd_buf, rcfcd_scale.
//
// Each received byte is taken in one cycle while the decoder is idle. The byte
// that completes a frame of type 0x16 starts the unpack sequence and holds off
// further bytes (o_stall high) until all 16 channel items are delivered. Each
// channel takes one or two buffer reads plus a pass through the shared
// multiplier of the scaling unit and one output state. The 22 channel bytes,
// the type check and the 16 channels hold the input after a completed frame;
// stalls on the output lengthen the hold. Other frame types hold the input
// only for the type check. The buffer read port and the single multiplier
// set the length of the hold. The sync byte r_sync resets to 200 and is written
// through the configuration port, which is always ready.
module rc_frame_channel_decoder import rcfcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_raw_value,
    output logic [11:0] o_pulse_us,
    output logic        o_last_channel,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_TYPE_RD  = 8'b0000_0010,
        S_TYPE_CHK = 8'b0000_0100,
        S_RD       = 8'b0000_1000,
        S_ACC      = 8'b0001_0000,
        S_GO       = 8'b0010_0000,
        S_WAIT     = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [7:0]          r_sync;
    logic [ADDR_W-1:0]   r_pos;
    logic [LEN_W-1:0]    r_len;
    logic [ADDR_W-1:0]   r_rdpos;
    logic [ACC_W-1:0]    r_acc;
    logic [NBITS_W-1:0]  r_nbits;
    logic [3:0]          r_ch;

    logic                accept;
    logic                wr_en;
    logic [ADDR_W:0]     pos_inc;
    logic                frame_end;
    logic [ADDR_W-1:0]   rd_addr;
    logic [7:0]          rd_data;
    logic [NBITS_W-1:0]  nbits_add, nbits_sub;
    logic                last;
    logic                sc_done;
    logic [11:0]         sc_pulse;

    assign accept    = i_valid && !o_stall;
    assign pos_inc   = (ADDR_W+1)'(r_pos) + (ADDR_W+1)'(1);
    assign frame_end = ((LEN_W+1)'(pos_inc) >= (LEN_W+1)'(r_len) + (LEN_W+1)'(2));
    assign wr_en     = accept && ((r_pos != '0) || (i_rx_data == r_sync));
    assign rd_addr   = (r_state == S_TYPE_RD) ? ADDR_W'(TYPE_BYTE) : r_rdpos;
    assign nbits_add = r_nbits + NBITS_W'(8);
    assign nbits_sub = r_nbits - NBITS_W'(RAW_BITS);
    assign last      = (r_ch == 4'(CH_COUNT - 1));

    rcfcd_buf u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (i_rx_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rcfcd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_GO),
        .i_raw   (r_acc[RAW_BITS-1:0]),
        .o_done  (sc_done),
        .o_pulse (sc_pulse)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (r_pos > ADDR_W'(1)) && frame_end) n_state = S_TYPE_RD;
            end
            S_TYPE_RD:  n_state = S_TYPE_CHK;
            S_TYPE_CHK: n_state = (rd_data == TYPE_RC) ? S_RD : S_IDLE;
            S_RD:       n_state = S_ACC;
            S_ACC:      n_state = (nbits_add >= NBITS_W'(RAW_BITS)) ? S_GO : S_RD;
            S_GO:       n_state = S_WAIT;
            S_WAIT:     if (sc_done) n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    if (last) begin
                        n_state = S_IDLE;
                    end else if (nbits_sub >= NBITS_W'(RAW_BITS)) begin
                        n_state = S_GO;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sync  <= SYNC_RESET;
            r_pos   <= '0;
            r_len   <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_sync <= i_cfg_data;
            end
            if (accept) begin
                if (r_pos == '0) begin
                    if (i_rx_data == r_sync) r_pos <= ADDR_W'(1);
                end else if (r_pos == ADDR_W'(1)) begin
                    r_len <= i_rx_data[LEN_W-1:0];
                    if ((i_rx_data == 8'd0) || (i_rx_data > 8'(MAX_LEN))) begin
                        r_pos <= '0;
                    end else begin
                        r_pos <= ADDR_W'(2);
                    end
                end else if (frame_end) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= pos_inc[ADDR_W-1:0];
                end
            end
            if (r_state == S_TYPE_CHK) begin
                r_ch <= '0;
            end else if ((r_state == S_OUT) && !i_stall) begin
                r_ch <= r_ch + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_TYPE_CHK: begin
                r_rdpos <= ADDR_W'(FIRST_CH_BYTE);
                r_acc   <= '0;
                r_nbits <= '0;
            end
            S_ACC: begin
                r_acc   <= r_acc | (ACC_W'(rd_data) << r_nbits);
                r_nbits <= nbits_add;
                r_rdpos <= r_rdpos + ADDR_W'(1);
            end
            S_OUT: begin
                if (!i_stall) begin
                    r_acc   <= r_acc >> RAW_BITS;
                    r_nbits <= nbits_sub;
                end
            end
            default: ;
        endcase
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_channel_index = r_ch;
    assign o_raw_value     = r_acc[RAW_BITS-1:0];
    assign o_pulse_us      = sc_pulse;
    assign o_last_channel  = last;
    assign o_cfg_ready     = 1'b1;

endmodule

[hdl/rcfcd_buf.sv]
// Frame byte buffer: one write port, one registered read port.
// Per-entry valid bits cleared at reset make unwritten entries read as zero.
// Depends on rcfcd_pkg.
module rcfcd_buf import rcfcd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0]           r_mem [BUF_BYTES];
    logic [BUF_BYTES-1:0] r_valid;
    logic [7:0]           r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'd0;

endmodule

[hdl/rcfcd_scale.sv]
// Pulse width scaling unit: one shared multiplier stepped through magnitude,
// reciprocal and correction products to form (raw-172)*1000/1639+1000.
// Depends on rcfcd_pkg.
module rcfcd_scale import rcfcd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RAW_BITS-1:0] i_raw,
    output logic                o_done,
    output logic [11:0]         o_pulse
);

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_MAG  = 4'b0010,
        SC_RCP  = 4'b0100,
        SC_FIX  = 4'b1000
    } t_sc_state;

    t_sc_state           r_state, n_state;
    logic                r_neg;
    logic [RAW_BITS-1:0] r_mag;
    logic [MAG_W-1:0]    r_m;
    logic [RAW_BITS-1:0] r_q;
    logic [11:0]         r_pulse;
    logic                r_done;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic [MAG_W-1:0]    rem;
    logic [RAW_BITS-1:0] q_fix;

    always_comb begin
        case (r_state)
            SC_MAG: begin
                mul_a = MUL_W'(r_mag);
                mul_b = MUL_W'(US_BASE);
            end
            SC_RCP: begin
                mul_a = MUL_W'(r_m);
                mul_b = RECIP;
            end
            SC_FIX: begin
                mul_a = MUL_W'(r_q);
                mul_b = MUL_W'(DIVISOR);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rem   = r_m - prod[MAG_W-1:0];
    assign q_fix = r_q + RAW_BITS'(rem >= MAG_W'(DIVISOR));

    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: if (i_start) n_state = SC_MAG;
            SC_MAG:  n_state = SC_RCP;
            SC_RCP:  n_state = SC_FIX;
            SC_FIX:  n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == SC_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    r_neg <= (i_raw < RAW_BITS'(RAW_MIN));
                    r_mag <= (i_raw < RAW_BITS'(RAW_MIN)) ? RAW_BITS'(RAW_MIN) - i_raw
                                                          : i_raw - RAW_BITS'(RAW_MIN);
                end
            end
            SC_MAG: r_m <= prod[MAG_W-1:0];
            SC_RCP: r_q <= prod[RCP_SHIFT +: RAW_BITS];
            SC_FIX: r_pulse <= r_neg ? 12'(US_BASE) - 12'(q_fix) : 12'(US_BASE) + 12'(q_fix);
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_pulse = r_pulse;

endmodule
